[rtl/core/cic_mass_deposit_3d_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the cloud-in-cell deposit block
// Implication checks in the same cycle and in the next cycle.
// ----------------------------------------------------------------------------
`ifndef CIC_MASS_DEPOSIT_3D_ASSERT_SVH
`define CIC_MASS_DEPOSIT_3D_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define CMD3D_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cic deposit assertion failed");

// Next-cycle implication, disabled during reset.
`define CMD3D_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cic deposit assertion failed");

`endif

[rtl/core/cmd3d_pkg.sv]
// ----------------------------------------------------------------------------
// Cloud-in-cell deposit package
// Item types, controller state, command and status groups, constants.
// ----------------------------------------------------------------------------
package cmd3d_pkg;

   localparam logic [16:0] ONE_Q16         = 17'h1_0000;
   localparam logic [31:0] SCALE_RESET     = 32'h0001_0000;
   localparam logic        FUNC_DEPOSIT    = 1'b0;
   localparam logic        FUNC_READ       = 1'b1;
   localparam logic [3:0]  CORNER_CNT_LAST = 4'd9;

   typedef struct packed {
      logic        func;
      logic [31:0] pos_x;
      logic [31:0] pos_y;
      logic [31:0] pos_z;
      logic [15:0] mass;
      logic [14:0] cell_index;
   } req_type;

   typedef struct packed {
      logic [39:0] density;
      logic        overflow;
   } rsp_type;

   typedef enum logic [7:0] {
      ST_CLEAR  = 8'b0000_0001,
      ST_IDLE   = 8'b0000_0010,
      ST_AXIS   = 8'b0000_0100,
      ST_SPLIT  = 8'b0000_1000,
      ST_CORNER = 8'b0001_0000,
      ST_RDREQ  = 8'b0010_0000,
      ST_RDWB   = 8'b0100_0000,
      ST_DONE   = 8'b1000_0000
   } state_type;

   typedef struct packed {
      logic       clear_en;
      logic       load;
      logic       axis_en;
      logic       split_en;
      logic       corner_en;
      logic [2:0] corner;
      logic       rd_issue;
      logic       rd_wb;
      logic       done;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic rsp_free;
   } sts_type;

endpackage

[rtl/core/cmd3d_ram.sv]
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cmd3d_ram #(
   parameter int unsigned WIDTH = 40,
   parameter int unsigned DEPTH = 32768
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[rtl/core/cmd3d_ctrl.sv]
// ----------------------------------------------------------------------------
// Cloud-in-cell deposit controller
// Sequences the clearing pass, deposit corners and read-and-clear items.
// ----------------------------------------------------------------------------
module cmd3d_ctrl import cmd3d_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_func,
   output logic    req_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type  state_ff, state_in;
   logic [3:0] cnt_ff, cnt_in;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_en = 1'b1;
            if (sts.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = (req_func == FUNC_READ) ? ST_RDREQ : ST_AXIS;
            end
         end
         ST_AXIS: begin
            cmd.axis_en = 1'b1;
            state_in    = ST_SPLIT;
         end
         ST_SPLIT: begin
            cmd.split_en = 1'b1;
            cnt_in       = '0;
            state_in     = ST_CORNER;
         end
         ST_CORNER: begin
            cmd.corner_en = ~cnt_ff[3];
            cmd.corner    = cnt_ff[2:0];
            cnt_in        = cnt_ff + 4'd1;
            if (cnt_ff == CORNER_CNT_LAST) begin
               state_in = ST_DONE;
            end
         end
         ST_RDREQ: begin
            cmd.rd_issue = 1'b1;
            state_in     = ST_RDWB;
         end
         ST_RDWB: begin
            cmd.rd_wb = 1'b1;
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            if (sts.rsp_free) begin
               cmd.done = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

[rtl/core/cmd3d_dp.sv]
// ----------------------------------------------------------------------------
// Cloud-in-cell deposit datapath
// Axis scaling, trilinear weights, corner pipeline, grid memory and output.
// ----------------------------------------------------------------------------
`include "cic_mass_deposit_3d_assert.svh"

module cmd3d_dp import cmd3d_pkg::*; #(
   parameter int unsigned GRID = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  req_type     req_data,
   input  logic        csr_we,
   input  logic [31:0] csr_wdata,
   input  cmd_type     cmd,
   output sts_type     sts,
   input  logic        rsp_stall,
   output logic        rsp_valid,
   output rsp_type     rsp_data
);

   localparam int unsigned CELLS = GRID * GRID * GRID;
   localparam int unsigned G2    = GRID * GRID;
   localparam int unsigned CW    = $clog2(GRID);
   localparam int unsigned AW    = $clog2(CELLS);

   logic [31:0]   scale_ff;
   req_type       req_ff;
   logic [31:0]   pos [3];
   logic [63:0]   p_ff [3];
   logic [CW-1:0] lo_in [3];
   logic [CW-1:0] hi_in [3];
   logic [16:0]   frac_in [3];
   logic [CW-1:0] lo_ff [3];
   logic [CW-1:0] hi_ff [3];
   logic [16:0]   frac_ff [3];
   logic [16:0]   wt [3];
   logic [CW-1:0] crd [3];
   logic [33:0]   wxy_full;
   logic [32:0]   mwz_full;
   logic [64:0]   prod_full;
   logic [32:0]   wxy_ff;
   logic [31:0]   mwz_ff;
   logic [AW-1:0] addr_in;
   logic [AW-1:0] a_addr_ff;
   logic          a_vld_ff;
   logic [31:0]   contrib_ff;
   logic [AW-1:0] b_addr_ff;
   logic          b_vld_ff;
   logic [40:0]   sum;
   logic          sat;
   logic          rd_ok;
   logic [AW-1:0] rd_addr;
   logic [AW-1:0] clr_ff;
   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic [39:0]   ram_wdata;
   logic          ram_re;
   logic [AW-1:0] ram_raddr;
   logic [39:0]   ram_rdata;
   logic [39:0]   density_ff;
   logic          flag_ff;
   logic          rsp_valid_ff;
   rsp_type       rsp_data_ff;

   assign pos[0] = req_ff.pos_x;
   assign pos[1] = req_ff.pos_y;
   assign pos[2] = req_ff.pos_z;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= SCALE_RESET;
      end else if (csr_we) begin
         scale_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
   end

   // Positions beyond the grid pin to the top cell with all weight on the
   // wrapped upper neighbor.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (p_ff[i][63:32] >= 32'(GRID)) begin
            lo_in[i]   = CW'(GRID - 1);
            frac_in[i] = ONE_Q16;
         end else begin
            lo_in[i]   = p_ff[i][CW+31:32];
            frac_in[i] = {1'b0, p_ff[i][31:16]};
         end
         hi_in[i] = (lo_in[i] == CW'(GRID - 1)) ? '0 : lo_in[i] + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         if (cmd.axis_en) begin
            p_ff[i] <= scale_ff * pos[i];
         end
         if (cmd.split_en) begin
            lo_ff[i]   <= lo_in[i];
            hi_ff[i]   <= hi_in[i];
            frac_ff[i] <= frac_in[i];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (cmd.corner[2-i]) begin
            wt[i]  = frac_ff[i];
            crd[i] = hi_ff[i];
         end else begin
            wt[i]  = ONE_Q16 - frac_ff[i];
            crd[i] = lo_ff[i];
         end
      end
      wxy_full = wt[0] * wt[1];
      mwz_full = req_ff.mass * wt[2];
      addr_in  = AW'(crd[0]) * AW'(G2) + AW'(crd[1]) * AW'(GRID) + AW'(crd[2]);
   end

   assign prod_full = wxy_ff * mwz_ff;

   always_ff @(posedge clock) begin
      wxy_ff     <= wxy_full[32:0];
      mwz_ff     <= mwz_full[31:0];
      a_addr_ff  <= addr_in;
      contrib_ff <= prod_full[63:32];
      b_addr_ff  <= a_addr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= cmd.corner_en;
         b_vld_ff <= a_vld_ff;
      end
   end

   assign sum     = {1'b0, ram_rdata} + 41'(contrib_ff);
   assign sat     = sum[40];
   assign rd_ok   = 32'(req_ff.cell_index) < 32'(CELLS);
   assign rd_addr = AW'(req_ff.cell_index);

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = clr_ff;
      ram_wdata = '0;
      if (cmd.clear_en) begin
         ram_we = 1'b1;
      end else if (b_vld_ff) begin
         ram_we    = 1'b1;
         ram_waddr = b_addr_ff;
         ram_wdata = sat ? '1 : sum[39:0];
      end else if (cmd.rd_wb && rd_ok) begin
         ram_we    = 1'b1;
         ram_waddr = rd_addr;
      end
      ram_re    = a_vld_ff | (cmd.rd_issue & rd_ok);
      ram_raddr = a_vld_ff ? a_addr_ff : rd_addr;
   end

   cmd3d_ram #(
      .WIDTH (40),
      .DEPTH (CELLS)
   ) u_grid (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear_en) begin
         clr_ff <= clr_ff + AW'(1);
      end
   end

   assign sts.clear_last = (clr_ff == AW'(CELLS - 1));

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         density_ff <= '0;
      end else if (cmd.rd_wb && rd_ok) begin
         density_ff <= ram_rdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flag_ff <= 1'b0;
      end else if (b_vld_ff && sat) begin
         flag_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.done) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.done) begin
         rsp_data_ff.density  <= density_ff;
         rsp_data_ff.overflow <= flag_ff;
      end
   end

   assign sts.rsp_free = ~rsp_valid_ff | ~rsp_stall;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_data_ff;

   `CMD3D_ASSERT_IMPL(a_rmw_addr_differ, clock, reset, a_vld_ff && b_vld_ff, a_addr_ff != b_addr_ff)
   `CMD3D_ASSERT_NEXT(a_flag_sticky, clock, reset, flag_ff, flag_ff)
   `CMD3D_ASSERT_IMPL(a_clear_quiet, clock, reset, cmd.clear_en, !a_vld_ff && !b_vld_ff)
   `CMD3D_ASSERT_IMPL(a_done_drained, clock, reset, cmd.done, !a_vld_ff && !b_vld_ff)

endmodule

[rtl/core/cic_mass_deposit_3d.sv]
// ----------------------------------------------------------------------------
// Cloud-in-cell mass deposit, 3D periodic grid
// Deposits particle mass onto GRID^3 cells and reads and clears single cells.
// ----------------------------------------------------------------------------
//   Channel   Direction   Ports
//   request   in          req_valid, req_stall, req_data
//   response  out         rsp_valid, rsp_stall, rsp_data
//   config    in          csr_we, csr_wdata
//
// After reset a clearing pass zeroes the grid, one cell per cycle, with
// req_stall held high.
// A deposit item runs axis scale, weight split, then eight read-modify-writes
// through the grid RAM's read and write port pair, then a pipeline drain.
// A read item issues a grid read, then captures and clears the cell when
// its index is in range. A finished item waits in the output register
// while rsp_stall is high, and the next item is accepted meanwhile.
// ----------------------------------------------------------------------------
module cic_mass_deposit_3d import cmd3d_pkg::*; #(
   parameter int unsigned GRID = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [31:0] csr_wdata
);

   cmd_type cmd;
   sts_type sts;

   cmd3d_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_data.func),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   cmd3d_dp #(
      .GRID (GRID)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
